// ----- rtl/u8d_pkg.sv -----
// Package for the UTF-8 stream decoder: error codes, byte masks and limits.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package u8d_pkg;

    localparam int unsigned CpWidth = 21;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BAD_START   = 3'd1,
        ERR_BAD_CONT    = 3'd2,
        ERR_OVERLONG    = 3'd3,
        ERR_TERMINATION = 3'd4
    } t_err;

    typedef logic [CpWidth-1:0] t_cp;

    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Code  = 8'hF0;
    localparam logic [7:0] ContMask   = 8'hC0;
    localparam logic [7:0] ContCode   = 8'h80;

    localparam t_cp Limit1 = t_cp'(21'h80);
    localparam t_cp Limit2 = t_cp'(21'h800);
    localparam t_cp Limit3 = t_cp'(21'h10000);

    function automatic logic [2:0] needed_length(input t_cp v);
        logic [2:0] len;
        if (v < Limit1) begin
            len = 3'd1;
        end else if (v < Limit2) begin
            len = 3'd2;
        end else if (v < Limit3) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/u8d_if.sv -----
// Valid/ready channel interfaces for the UTF-8 stream decoder: byte requests in,
// decoded results out. Depends on u8d_pkg.
`default_nettype none

interface u8d_in_if import u8d_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
    logic valid;
    logic ready;
    t_cp  code_point;
    logic char_ready;
    t_err error_code;

    modport source (output valid, code_point, char_ready, error_code, input ready);
    modport sink   (input valid, code_point, char_ready, error_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/utf8_stream_decoder_top.sv -----
// UTF-8 stream decoder top level: input register, decode step, result register.
// Depends on u8d_pkg and the channel interfaces in u8d_if.
//
// One byte request per cycle unless the sink stalls, one result per byte. A byte
// is held in the input register, decoded against the pending sequence state and
// written to the result register together with the state update; the input
// register takes a new byte while a result waits only if it is empty, so full
// throughput holds as long as the sink takes a result each cycle. Each result
// carries the code point (zero unless char_ready), char_ready and an error
// code; invalid continuation bytes are dropped with the pending sequence kept,
// and a byte flagged end_of_stream always leaves the decoder idle.
`default_nettype none

module utf8_stream_decoder_top import u8d_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic [1:0] r_rem;
    logic [2:0] r_seq;
    t_cp        r_acc;

    logic       r_out_valid;
    t_cp        r_cp;
    logic       r_rdy;
    t_err       r_err;

    logic [1:0] n_rem;
    logic [2:0] n_seq;
    t_cp        n_acc;
    t_cp        n_cp;
    logic       n_rdy;
    t_err       n_err;

    logic       w_adv;
    t_cp        w_shift;
    logic [1:0] w_rem_dec;

    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    assign w_shift   = {r_acc[CpWidth-7:0], r_byte[5:0]};
    assign w_rem_dec = r_rem - 2'd1;

    always_comb begin
        n_rem = r_rem;
        n_seq = r_seq;
        n_acc = r_acc;
        n_cp  = '0;
        n_rdy = 1'b0;
        n_err = ERR_NONE;
        if (r_rem == 2'd0) begin
            priority if (!r_byte[7]) begin
                n_cp  = t_cp'(r_byte);
                n_rdy = 1'b1;
            end else if ((r_byte & Lead2Mask) == Lead2Code) begin
                n_acc = t_cp'(r_byte[4:0]);
                n_seq = 3'd2;
                n_rem = 2'd1;
            end else if ((r_byte & Lead3Mask) == Lead3Code) begin
                n_acc = t_cp'(r_byte[3:0]);
                n_seq = 3'd3;
                n_rem = 2'd2;
            end else if ((r_byte & Lead4Mask) == Lead4Code) begin
                n_acc = t_cp'(r_byte[2:0]);
                n_seq = 3'd4;
                n_rem = 2'd3;
            end else begin
                n_err = ERR_BAD_START;
            end
        end else if ((r_byte & ContMask) != ContCode) begin
            n_err = ERR_BAD_CONT;
        end else if (w_rem_dec != 2'd0) begin
            n_acc = w_shift;
            n_rem = w_rem_dec;
        end else begin
            if (needed_length(w_shift) == r_seq) begin
                n_cp  = w_shift;
                n_rdy = 1'b1;
            end else begin
                n_err = ERR_OVERLONG;
            end
            n_rem = '0;
            n_seq = '0;
            n_acc = '0;
        end
        if (r_last) begin
            if (n_rem != 2'd0 && n_err == ERR_NONE) begin
                n_err = ERR_TERMINATION;
            end
            n_rem = '0;
            n_seq = '0;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rem       <= '0;
            r_seq       <= '0;
            r_acc       <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_rem       <= n_rem;
                r_seq       <= n_seq;
                r_acc       <= n_acc;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.end_of_stream;
        end
        if (w_adv) begin
            r_cp  <= n_cp;
            r_rdy <= n_rdy;
            r_err <= n_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_cp;
    assign o_out.char_ready = r_rdy;
    assign o_out.error_code = r_err;

    a_pending_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem != 2'd0 |-> r_seq > {1'b0, r_rem} && r_seq <= 3'd4)
        else $error("pending length does not match remaining count");

    a_idle_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem == 2'd0 |-> r_acc == '0 && r_seq == 3'd0)
        else $error("idle state not cleared");

    a_char_no_err : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rdy |-> r_err == ERR_NONE)
        else $error("character emitted with an error");

    a_cp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_rdy |-> r_cp == '0)
        else $error("code point set without a character");

    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_last |=> r_rem == 2'd0)
        else $error("end of stream left a sequence pending");

endmodule

`default_nettype wire
